@@ rtl/core/pdo_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdo_pkg
// Shared types and constants for the power data object decoder: object type
// codes, field widths and the item record that moves down the divider chain.
// ----------------------------------------------------------------------------
package pdo_pkg;

   // object type codes, bits 31:30
   localparam logic [1:0] TypeFixed     = 2'd0;
   localparam logic [1:0] TypeBattery   = 2'd1;
   localparam logic [1:0] TypeVariable  = 2'd2;
   localparam logic [1:0] TypeAugmented = 2'd3;

   // augmented subtype codes, bits 29:28
   localparam logic [1:0] AugPps    = 2'd0;
   localparam logic [1:0] AugEprAvs = 2'd1;

   // field widths
   localparam int RawW   = 32;
   localparam int KindW  = 2;
   localparam int VoltW  = 16;
   localparam int CurW   = 16;
   localparam int PwrW   = 19;
   localparam int DivW   = 9;   // avs maximum voltage in 100 mV units
   localparam int NumW   = 22;  // watts * 10000

   // one divider cell per quotient bit below the saturation limit
   localparam int DivCells = CurW;

   // decoded fields plus divider control
   typedef struct packed {
      logic [KindW-1:0] object_type;
      logic [KindW-1:0] augmented_kind;
      logic [VoltW-1:0] volt_max_mv;
      logic [VoltW-1:0] volt_min_mv;
      logic [CurW-1:0]  curr_ma;
      logic [PwrW-1:0]  pwr_mw;
      logic             use_div;
      logic             saturate;
   } pdo_info_type;

   // item record carried from cell to cell
   typedef struct packed {
      pdo_info_type    info;
      logic [DivW-1:0] divisor;
      logic [DivW-1:0] rem;
      logic [CurW-1:0] quo;   // numerator bits still to use, quotient bits shift in
   } pdo_work_type;

endpackage

@@ rtl/core/power_data_object_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_data_object_decoder
// Decodes one usb pd power data object per item into type, subtype and
// voltage, current and power values.
// ----------------------------------------------------------------------------
// Takes one item per cycle while the result side does not stall and returns
// each result in order after one decode stage and a chain of 16 division
// cells, each producing one bit of the epr avs current quotient. Every item
// flows through the whole chain, whatever its object type. Stages collapse
// bubbles, so a stall on the result side fills the chain before the input
// side is stalled.
module power_data_object_decoder (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pdo_pkg::RawW-1:0]   req_raw_object,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [pdo_pkg::KindW-1:0]  rsp_object_type,
   output logic [pdo_pkg::KindW-1:0]  rsp_augmented_kind,
   output logic [pdo_pkg::VoltW-1:0]  rsp_volt_max_mv,
   output logic [pdo_pkg::VoltW-1:0]  rsp_volt_min_mv,
   output logic [pdo_pkg::CurW-1:0]   rsp_curr_ma,
   output logic [pdo_pkg::PwrW-1:0]   rsp_pwr_mw
);
   import pdo_pkg::*;

   localparam int Stages = DivCells + 1;
   localparam int CntW   = $clog2(Stages + 1);

   logic         valid_s [0:DivCells];
   logic         ready_s [0:DivCells];
   pdo_work_type work_s  [0:DivCells];
   logic         in_ready;
   pdo_work_type last;
   logic         req_fire;
   logic         rsp_fire;
   logic [CntW-1:0] in_flight_ff;
   logic [CntW-1:0] in_flight_in;

   // front decode stage
   pdo_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (in_ready),
      .in_raw    (req_raw_object),
      .out_valid (valid_s[0]),
      .out_ready (ready_s[0]),
      .out_work  (work_s[0])
   );

   // division cell chain
   for (genvar i = 0; i < DivCells; i++) begin : g_cell
      pdo_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_s[i]),
         .in_ready  (ready_s[i]),
         .in_work   (work_s[i]),
         .out_valid (valid_s[i+1]),
         .out_ready (ready_s[i+1]),
         .out_work  (work_s[i+1])
      );
   end

   assign req_stall         = !in_ready;
   assign ready_s[DivCells] = !rsp_stall;

   // result selection
   assign last               = work_s[DivCells];
   assign rsp_valid          = valid_s[DivCells];
   assign rsp_object_type    = last.info.object_type;
   assign rsp_augmented_kind = last.info.augmented_kind;
   assign rsp_volt_max_mv    = last.info.volt_max_mv;
   assign rsp_volt_min_mv    = last.info.volt_min_mv;
   assign rsp_pwr_mw         = last.info.pwr_mw;

   always_comb begin
      priority if (!last.info.use_div) begin
         rsp_curr_ma = last.info.curr_ma;
      end else if (last.info.saturate) begin
         rsp_curr_ma = '1;
      end else begin
         rsp_curr_ma = last.quo;
      end
   end

   // items in flight
   assign req_fire = req_valid && !req_stall;
   assign rsp_fire = rsp_valid && !rsp_stall;

   always_comb begin
      in_flight_in = in_flight_ff;
      if (req_fire && !rsp_fire) begin
         in_flight_in = in_flight_ff + CntW'(1);
      end else if (rsp_fire && !req_fire) begin
         in_flight_in = in_flight_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_flight_ff <= '0;
      end else begin
         in_flight_ff <= in_flight_in;
      end
   end

   // input is only stalled when every stage holds an item
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_flight_ff == CntW'(Stages))
      else $error("input stalled with free stages");

   // item count never exceeds the number of stages
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      in_flight_ff <= CntW'(Stages))
      else $error("more items in flight than stages");

   // subtype only reported for augmented objects
   a_kind_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_object_type != TypeAugmented |-> rsp_augmented_kind == '0)
      else $error("subtype set on non-augmented object");

   // battery objects carry no current and no minimum voltage
   a_battery_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_object_type == TypeBattery
      |-> rsp_curr_ma == '0 && rsp_volt_min_mv == '0)
      else $error("battery object with current or minimum voltage");

endmodule

@@ rtl/core/pdo_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdo_decode
// Front stage: splits the raw object into fields, scales them to mV, mA and
// mW and sets up the avs current division for the cell chain.
// ----------------------------------------------------------------------------
module pdo_decode (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [pdo_pkg::RawW-1:0]   in_raw,
   output logic                       out_valid,
   input  logic                       out_ready,
   output pdo_pkg::pdo_work_type      out_work
);
   import pdo_pkg::*;

   logic         valid_ff;
   pdo_work_type work_ff;
   pdo_work_type work_in;

   logic [9:0]      mul_a;
   logic [9:0]      mul_b;
   logic [19:0]     prod;
   logic [DivW-1:0] v100;
   logic [7:0]      watts;
   logic [NumW-1:0] num;

   // shared field product for fixed, variable and pps power
   assign prod  = 20'(mul_a) * 20'(mul_b);
   assign v100  = in_raw[25:17];
   assign watts = in_raw[7:0];
   assign num   = NumW'(watts) * NumW'(10000);

   // field decode
   always_comb begin
      work_in = '0;
      mul_a   = '0;
      mul_b   = '0;
      work_in.info.object_type = in_raw[31:30];
      unique case (in_raw[31:30])
         TypeFixed: begin
            mul_a = in_raw[19:10];
            mul_b = in_raw[9:0];
            work_in.info.volt_max_mv = VoltW'(in_raw[19:10]) * VoltW'(50);
            work_in.info.curr_ma     = CurW'(in_raw[9:0]) * CurW'(10);
            work_in.info.pwr_mw      = PwrW'(prod >> 1);
         end
         TypeVariable: begin
            mul_a = in_raw[29:20];
            mul_b = in_raw[9:0];
            work_in.info.volt_max_mv = VoltW'(in_raw[29:20]) * VoltW'(50);
            work_in.info.volt_min_mv = VoltW'(in_raw[19:10]) * VoltW'(50);
            work_in.info.curr_ma     = CurW'(in_raw[9:0]) * CurW'(10);
            work_in.info.pwr_mw      = PwrW'(prod >> 1);
         end
         TypeBattery: begin
            work_in.info.volt_max_mv = VoltW'(in_raw[29:20]) * VoltW'(50);
            work_in.info.pwr_mw      = PwrW'(in_raw[9:0]) * PwrW'(250);
         end
         default: begin
            work_in.info.augmented_kind = in_raw[29:28];
            unique case (in_raw[29:28])
               AugPps: begin
                  // 100 mV times 50 mA over 1000 is five per unit product
                  mul_a = 10'(in_raw[24:17]);
                  mul_b = 10'(in_raw[6:0]) * 10'd5;
                  work_in.info.volt_max_mv = VoltW'(in_raw[24:17]) * VoltW'(100);
                  work_in.info.volt_min_mv = VoltW'(in_raw[15:8]) * VoltW'(100);
                  work_in.info.curr_ma     = CurW'(in_raw[6:0]) * CurW'(50);
                  work_in.info.pwr_mw      = PwrW'(prod);
               end
               AugEprAvs: begin
                  work_in.info.volt_max_mv = VoltW'(v100) * VoltW'(100);
                  work_in.info.volt_min_mv = VoltW'(in_raw[15:8]) * VoltW'(100);
                  work_in.info.pwr_mw      = PwrW'(watts) * PwrW'(1000);
                  work_in.info.use_div     = (v100 != '0);
                  // quotient over 16 bits when the top numerator bits reach the divisor
                  work_in.info.saturate = (DivW'(num[NumW-1:CurW]) >= v100);
                  work_in.divisor = v100;
                  work_in.rem     = DivW'(num[NumW-1:CurW]);
                  work_in.quo     = num[CurW-1:0];
               end
               default: begin
                  // unknown subtype leaves all values at zero
               end
            endcase
         end
      endcase
   end

   // stage register with bubble collapse
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

endmodule

@@ rtl/core/pdo_div_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdo_div_cell
// One restoring division step: shifts in the next numerator bit, subtracts
// the divisor when it fits and shifts the quotient bit in.
// ----------------------------------------------------------------------------
module pdo_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  pdo_pkg::pdo_work_type in_work,
   output logic                  out_valid,
   input  logic                  out_ready,
   output pdo_pkg::pdo_work_type out_work
);
   import pdo_pkg::*;

   logic         valid_ff;
   pdo_work_type work_ff;
   pdo_work_type work_in;
   logic [DivW:0] trial;
   logic          fits;

   // one quotient bit
   assign trial = {in_work.rem, in_work.quo[CurW-1]};
   assign fits  = (trial >= {1'b0, in_work.divisor});

   always_comb begin
      work_in     = in_work;
      work_in.rem = fits ? DivW'(trial - {1'b0, in_work.divisor}) : trial[DivW-1:0];
      work_in.quo = {in_work.quo[CurW-2:0], fits};
   end

   // stage register with bubble collapse
   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         work_ff <= work_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_work  = work_ff;

   // remainder stays below the divisor on a live unsaturated division
   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      valid_ff && work_ff.info.use_div && !work_ff.info.saturate
      |-> work_ff.rem < work_ff.divisor)
      else $error("divider cell remainder not below divisor");

endmodule

@@ verif/tb_power_data_object_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_data_object_decoder
// Self-checking bench for the usb pd power data object decoder. A directed
// list of edge objects and 750 random objects are driven with
// random gaps while the result side stalls at random. Each accepted object
// is decoded by a local model and compared field by field, in order, with
// the results the block returns.
// ----------------------------------------------------------------------------
module tb_power_data_object_decoder;

   import pdo_pkg::*;

   // one decoded object as the result port presents it
   typedef struct packed {
      logic [KindW-1:0] object_type;
      logic [KindW-1:0] augmented_kind;
      logic [VoltW-1:0] volt_max_mv;
      logic [VoltW-1:0] volt_min_mv;
      logic [CurW-1:0]  curr_ma;
      logic [PwrW-1:0]  pwr_mw;
   } pdo_fields_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [RawW-1:0]   req_raw_object = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [KindW-1:0]  rsp_object_type;
   logic [KindW-1:0]  rsp_augmented_kind;
   logic [VoltW-1:0]  rsp_volt_max_mv;
   logic [VoltW-1:0]  rsp_volt_min_mv;
   logic [CurW-1:0]   rsp_curr_ma;
   logic [PwrW-1:0]   rsp_pwr_mw;

   logic [RawW-1:0]   objects_to_send[$];
   pdo_fields_type    predicted_decodes[$];
   int                error_count = 0;
   int                send_gap = 0;
   int                send_calm = 0;
   int                stall_left = 0;
   int                stall_calm = 0;

   power_data_object_decoder uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_raw_object     (req_raw_object),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_object_type    (rsp_object_type),
      .rsp_augmented_kind (rsp_augmented_kind),
      .rsp_volt_max_mv    (rsp_volt_max_mv),
      .rsp_volt_min_mv    (rsp_volt_min_mv),
      .rsp_curr_ma        (rsp_curr_ma),
      .rsp_pwr_mw         (rsp_pwr_mw)
   );

   // 20 ns clock
   always #10 clock = ~clock;

   // decode one power data object the way the block should
   function automatic pdo_fields_type decode_object(input logic [RawW-1:0] raw);
      pdo_fields_type d;
      logic [31:0] volt;
      logic [31:0] vmin;
      logic [31:0] amps;
      logic [31:0] milliwatts;
      logic [31:0] v100;
      logic [31:0] watts;
      d = '0;
      volt = '0;
      vmin = '0;
      amps = '0;
      milliwatts = '0;
      d.object_type = raw[31:30];
      case (raw[31:30])
         TypeFixed: begin
            volt = 32'(raw[19:10]);
            volt = volt * 50;
            amps = 32'(raw[9:0]);
            amps = amps * 10;
            milliwatts = (volt * amps) / 1000;
         end
         TypeVariable: begin
            volt = 32'(raw[29:20]);
            volt = volt * 50;
            vmin = 32'(raw[19:10]);
            vmin = vmin * 50;
            amps = 32'(raw[9:0]);
            amps = amps * 10;
            milliwatts = (volt * amps) / 1000;
         end
         TypeBattery: begin
            volt = 32'(raw[29:20]);
            volt = volt * 50;
            milliwatts = 32'(raw[9:0]);
            milliwatts = milliwatts * 250;
         end
         default: begin
            d.augmented_kind = raw[29:28];
            if (raw[29:28] == AugPps) begin
               volt = 32'(raw[24:17]);
               volt = volt * 100;
               vmin = 32'(raw[15:8]);
               vmin = vmin * 100;
               amps = 32'(raw[6:0]);
               amps = amps * 50;
               milliwatts = (volt * amps) / 1000;
            end else if (raw[29:28] == AugEprAvs) begin
               v100 = 32'(raw[25:17]);
               watts = 32'(raw[7:0]);
               volt = v100 * 100;
               vmin = 32'(raw[15:8]);
               vmin = vmin * 100;
               milliwatts = watts * 1000;
               // current from power and maximum voltage, zero voltage gives zero
               if (v100 != 0) begin
                  amps = (watts * 10000) / v100;
                  if (amps > 65535) amps = 32'd65535;
               end
            end
         end
      endcase
      d.volt_max_mv = volt[VoltW-1:0];
      d.volt_min_mv = vmin[VoltW-1:0];
      d.curr_ma     = amps[CurW-1:0];
      d.pwr_mw      = milliwatts[PwrW-1:0];
      return d;
   endfunction

   // random object, steered toward augmented objects and avs saturation
   function automatic logic [RawW-1:0] random_object();
      logic [RawW-1:0] raw;
      raw = $urandom();
      if ($urandom_range(0, 9) < 3) begin
         raw[31:30] = TypeAugmented;
         raw[29:28] = ($urandom_range(0, 3) == 0) ? AugPps : AugEprAvs;
      end
      if (raw[31:30] == TypeAugmented && raw[29:28] == AugEprAvs
          && $urandom_range(0, 2) == 0)
         raw[25:17] = 9'($urandom_range(0, 45));
      return raw;
   endfunction

   // idle length: mostly none or short, now and then long
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // driver: offer queued objects, record the decode of each accepted item
   always @(posedge clock) begin : object_driver
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_decodes.push_back(decode_object(req_raw_object));
         if (req_valid && req_stall) begin
            // hold the stalled item
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (objects_to_send.size() > 0) begin
            req_raw_object <= objects_to_send.pop_front();
            req_valid <= 1'b1;
            if (send_calm > 0) begin
               send_calm--;
               send_gap = 0;
            end else begin
               send_gap = idle_length();
               if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(20, 60);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor: random stall on the result side, compare each accepted item
   always @(posedge clock) begin : decode_monitor
      pdo_fields_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (predicted_decodes.size() == 0) begin
            $error("result item with no object outstanding");
            error_count++;
         end else begin
            want = predicted_decodes.pop_front();
            check_field("object_type", 32'(want.object_type), 32'(rsp_object_type));
            check_field("augmented_kind", 32'(want.augmented_kind),
                        32'(rsp_augmented_kind));
            check_field("volt_max_mv", 32'(want.volt_max_mv), 32'(rsp_volt_max_mv));
            check_field("volt_min_mv", 32'(want.volt_min_mv), 32'(rsp_volt_min_mv));
            check_field("curr_ma", 32'(want.curr_ma), 32'(rsp_curr_ma));
            check_field("pwr_mw", 32'(want.pwr_mw), 32'(rsp_pwr_mw));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (stall_calm > 0) begin
            stall_calm--;
         end else begin
            stall_left = idle_length();
            if ($urandom_range(0, 49) == 0) stall_calm = $urandom_range(20, 60);
         end
      end
   end

   // stimulus and end of run
   initial begin : stimulus
      // zero and all ones, the latter an unknown augmented subtype
      objects_to_send.push_back(32'h0000_0000);
      objects_to_send.push_back(32'hFFFF_FFFF);
      // fixed: full scale, typical 5 V 3 A, reserved bits only
      objects_to_send.push_back(32'h000F_FFFF);
      objects_to_send.push_back(32'h0001_912C);
      objects_to_send.push_back(32'h3FF0_0000);
      // variable: full scale and empty
      objects_to_send.push_back(32'hBFFF_FFFF);
      objects_to_send.push_back(32'h8000_0000);
      // battery: full scale and empty, current always zero
      objects_to_send.push_back(32'h7FFF_FFFF);
      objects_to_send.push_back(32'h4000_0000);
      // pps: empty, full fields with reserved bits, full fields alone
      objects_to_send.push_back(32'hC000_0000);
      objects_to_send.push_back(32'hCFFF_FFFF);
      objects_to_send.push_back({4'hC, 3'b000, 8'hFF, 1'b0, 8'hFF, 1'b0, 7'h7F});
      // epr avs: zero voltage, full scale, saturation edges
      objects_to_send.push_back(32'hD000_0000);
      objects_to_send.push_back({4'hD, 2'b11, 9'd0, 1'b1, 8'd200, 8'd140});
      objects_to_send.push_back(32'hDFFF_FFFF);
      objects_to_send.push_back({4'hD, 2'b00, 9'd1, 1'b0, 8'd50, 8'd255});
      objects_to_send.push_back({4'hD, 2'b00, 9'd38, 1'b0, 8'd0, 8'd255});
      objects_to_send.push_back({4'hD, 2'b00, 9'd39, 1'b0, 8'd0, 8'd255});
      objects_to_send.push_back({4'hD, 2'b00, 9'd480, 1'b0, 8'd150, 8'd0});
      // unknown subtypes give zero values
      objects_to_send.push_back(32'hE123_4567);
      objects_to_send.push_back(32'hF000_0000);
      objects_to_send.push_back(32'hFABC_DEF0);
      repeat (750) objects_to_send.push_back(random_object());

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent, nothing outstanding
      @(negedge clock);
      while (objects_to_send.size() != 0 || req_valid || predicted_decodes.size() != 0)
         @(negedge clock);
      repeat (40) @(posedge clock);

      if (error_count == 0)
         $display("tb_power_data_object_decoder: done, clean");
      else
         $display("tb_power_data_object_decoder: done, errors");
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #10_000_000;
      $display("tb_power_data_object_decoder: done, errors");
      $finish;
   end

endmodule

@@ power_data_object_decoder.f @@
rtl/core/pdo_pkg.sv
rtl/core/pdo_decode.sv
rtl/core/pdo_div_cell.sv
rtl/core/power_data_object_decoder.sv
verif/tb_power_data_object_decoder.sv
